### rtl/core/dtsv_pkg.sv
// ----------------------------------------------------------------------------
// dtsv_pkg
// Shared types, constants and helpers for the date / time string validator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsv_pkg;

  // string layout selected by the format register
  typedef enum logic [1:0] {
    MODE_DATE     = 2'd0,
    MODE_TIME     = 2'd1,
    MODE_DATETIME = 2'd2
  } mode_t;

  localparam logic [1:0] MODE_RESET = MODE_DATETIME;

  // required string lengths, and the count's saturation limit
  localparam logic [3:0] LEN_DATE     = 4'd8;
  localparam logic [3:0] LEN_TIME     = 4'd6;
  localparam logic [3:0] LEN_DATETIME = 4'd14;
  localparam logic [3:0] COUNT_MAX    = 4'd15;

  // time-only strings land at the hour position of the date-time layout
  localparam logic [3:0] TIME_OFFSET  = 4'd8;

  // field range limits
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;
  localparam logic [6:0] MONTH_MAX  = 7'd12;

  // year is kept modulo 400, enough for the leap rule
  localparam int unsigned YEAR_MOD  = 400;
  localparam int unsigned YMOD_W    = 9;

  // collected fields handed to the judge
  typedef struct packed {
    logic [3:0]        count;
    logic              bad;
    logic [YMOD_W-1:0] year_mod;
    logic [6:0]        month;
    logic [6:0]        day;
    logic [6:0]        hour;
    logic [6:0]        minute;
    logic [6:0]        second;
  } fields_t;

  // days in a month for a common year, month 1..12
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] days;
    case (month)
      4'd2:                      days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
      default:                   days = 5'd31;
    endcase
    return days;
  endfunction

  // decimal accumulate, wrapping to 7 bits
  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
    logic [9:0] t;
    t = {v, 3'b000} + {2'b00, v, 1'b0} + {6'd0, d};
    return t[6:0];
  endfunction

  // decimal accumulate modulo 400
  function automatic logic [YMOD_W-1:0] acc_mod400(input logic [YMOD_W-1:0] m,
                                                   input logic [3:0] d);
    logic [11:0] t;
    logic [11:0] r;
    t = {m, 3'b000} + {2'b00, m, 1'b0} + {8'd0, d};
    r = t;
    // t is below 4000, so at most nine multiples of 400 come off
    for (int k = 9; k >= 1; k--) begin
      if (r == t && t >= 12'(k * YEAR_MOD)) begin
        r = t - 12'(k * YEAR_MOD);
      end
    end
    return r[YMOD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/dtsv_judge.sv
// ----------------------------------------------------------------------------
// dtsv_judge
// Final verdict on a collected string: length, digits and field ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsv_judge (
  input  wire logic [1:0]      mode,
  input  wire dtsv_pkg::fields_t fld,
  output logic                 ok
);
  import dtsv_pkg::*;

  logic       leap;
  logic [4:0] max_day;
  logic       date_ok;
  logic       time_ok;

  // leap rule on the year modulo 400
  always_comb begin
    leap = 1'b0;
    if (fld.year_mod == '0) begin
      leap = 1'b1;
    end else if (fld.year_mod[1:0] == 2'b00 &&
                 fld.year_mod != YMOD_W'(100) &&
                 fld.year_mod != YMOD_W'(200) &&
                 fld.year_mod != YMOD_W'(300)) begin
      leap = 1'b1;
    end
  end

  // calendar checks
  always_comb begin
    max_day = month_days(fld.month[3:0]);
    if (fld.month == 7'd2 && leap) begin
      max_day = 5'd29;
    end
    date_ok = (fld.month >= 7'd1) && (fld.month <= MONTH_MAX) &&
              (fld.day >= 7'd1) && (fld.day <= {2'b00, max_day});
    time_ok = (fld.hour <= HOUR_MAX) && (fld.minute <= MINSEC_MAX) &&
              (fld.second <= MINSEC_MAX);
  end

  // verdict by format
  always_comb begin
    ok = 1'b0;
    if (!fld.bad) begin
      case (mode)
        MODE_DATE:     ok = (fld.count == LEN_DATE) && date_ok;
        MODE_TIME:     ok = (fld.count == LEN_TIME) && time_ok;
        MODE_DATETIME: ok = (fld.count == LEN_DATETIME) && date_ok && time_ok;
        default:       ok = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/date_time_string_validator.sv
// ----------------------------------------------------------------------------
// date_time_string_validator
// Checks a digit string, one byte per request, as a date, time or date-time.
// ----------------------------------------------------------------------------
// The block takes one character request per clock unless stalled, keeps a
// running count and the decimal fields of the string; an end request yields
// one result, valid_res, set when the string has exactly the length of the
// selected format (8 YYYYMMDD, 6 HHMMSS, 14 YYYYMMDDHHMMSS), holds only
// digits and gives a real Gregorian date and/or time. Each character
// updates a single field accumulator and the verdict is formed from those
// registers straight into the result register; an end request clears the
// fields, so a new string may follow it at once if not stalled. Input
// is stalled only while a finished result is waiting and out_stall is high.
// cfg_wdata selects the format (reset: date-time); write it between strings.
// ----------------------------------------------------------------------------
`default_nettype none

module date_time_string_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  // character requests
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_is_end,
  // results
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_valid_res
);
  import dtsv_pkg::*;

  logic [1:0] mode_r;
  fields_t    fld_r, fld_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       res_r, res_nxt;
  logic       in_acc;
  logic       is_digit;
  logic [3:0] digit;
  logic [3:0] pos;
  logic       collect;
  logic       ok;

  // handshake
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_valid_res = res_r;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // character decode and position in the date-time layout
  always_comb begin
    is_digit = (in_ch >= 8'h30) && (in_ch <= 8'h39);
    digit    = 4'(in_ch - 8'h30);
    pos      = fld_r.count;
    collect  = is_digit;
    case (mode_r)
      MODE_TIME: begin
        if (fld_r.count < LEN_TIME) begin
          pos = fld_r.count + TIME_OFFSET;
        end else begin
          collect = 1'b0;
        end
      end
      MODE_DATE, MODE_DATETIME: begin
        collect = is_digit;
      end
      default: collect = 1'b0;
    endcase
  end

  // field accumulation
  always_comb begin
    fld_nxt = fld_r;
    if (in_acc) begin
      if (in_is_end) begin
        fld_nxt = '0;
      end else begin
        if (!is_digit) begin
          fld_nxt.bad = 1'b1;
        end
        if (collect) begin
          if (pos < 4'd4) begin
            fld_nxt.year_mod = acc_mod400(fld_r.year_mod, digit);
          end else if (pos < 4'd6) begin
            fld_nxt.month = acc7(fld_r.month, digit);
          end else if (pos < 4'd8) begin
            fld_nxt.day = acc7(fld_r.day, digit);
          end else if (pos < 4'd10) begin
            fld_nxt.hour = acc7(fld_r.hour, digit);
          end else if (pos < 4'd12) begin
            fld_nxt.minute = acc7(fld_r.minute, digit);
          end else if (pos < 4'd14) begin
            fld_nxt.second = acc7(fld_r.second, digit);
          end
        end
        if (fld_r.count < COUNT_MAX) begin
          fld_nxt.count = fld_r.count + 4'd1;
        end
      end
    end
  end

  dtsv_judge u_judge (
    .mode (mode_r),
    .fld  (fld_r),
    .ok   (ok)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    if (in_acc && in_is_end) begin
      out_valid_nxt = 1'b1;
      res_nxt       = ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fld_r       <= fld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/dtsv_checker.sv
// ----------------------------------------------------------------------------
// dtsv_checker
// Port-level assertions for the date / time string validator.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsv_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_is_end,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_valid_res
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_valid_res))
    else $error("stalled result dropped or changed");

  // a new result only follows an accepted end request
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_is_end))
    else $error("result without end request");

  // a character request gives no result
  a_char_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_is_end && !(out_valid && out_stall) |=> !out_valid)
    else $error("result from a character request");

  // input only held back by a waiting, stalled result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");

endmodule

bind date_time_string_validator dtsv_checker u_dtsv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_is_end     (in_is_end),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_valid_res (out_valid_res)
);

`default_nettype wire
